/* rtl/dacc_pkg.sv */
// shared types, opcodes and constants of the decimal accumulator cpu
package dacc_pkg;

    localparam int MEM_WORDS     = 100;
    localparam int ADDR_W        = $clog2(MEM_WORDS);
    localparam int WORD_BITS_DEF = 32;
    localparam int IO_W          = 32;
    localparam int OPC_W         = 7;

    // instruction word split: opcode = word / 100, operand address = word % 100
    localparam int OP_SPLIT   = 100;
    localparam int INSN_LIMIT = OP_SPLIT * OP_SPLIT;
    localparam int SPLIT_W    = $clog2(INSN_LIMIT);
    localparam int DIV_SHIFT  = 19;
    localparam int DIV_RECIP  = (1 << DIV_SHIFT) / OP_SPLIT + 1;
    localparam int RECIP_W    = $clog2(DIV_RECIP + 1);

    localparam logic [OPC_W-1:0] OP_NOP   = 7'd0;
    localparam logic [OPC_W-1:0] OP_INPUT = 7'd10;
    localparam logic [OPC_W-1:0] OP_PRINT = 7'd11;
    localparam logic [OPC_W-1:0] OP_NOP2  = 7'd12;
    localparam logic [OPC_W-1:0] OP_LOAD  = 7'd20;
    localparam logic [OPC_W-1:0] OP_STORE = 7'd21;
    localparam logic [OPC_W-1:0] OP_ADD   = 7'd30;
    localparam logic [OPC_W-1:0] OP_SUB   = 7'd31;
    localparam logic [OPC_W-1:0] OP_DIV   = 7'd32;
    localparam logic [OPC_W-1:0] OP_MUL   = 7'd33;
    localparam logic [OPC_W-1:0] OP_MOD   = 7'd34;
    localparam logic [OPC_W-1:0] OP_POW   = 7'd35;
    localparam logic [OPC_W-1:0] OP_DEC   = 7'd38;
    localparam logic [OPC_W-1:0] OP_INC   = 7'd39;
    localparam logic [OPC_W-1:0] OP_JMP   = 7'd40;
    localparam logic [OPC_W-1:0] OP_JNEG  = 7'd41;
    localparam logic [OPC_W-1:0] OP_JPOS  = 7'd42;
    localparam logic [OPC_W-1:0] OP_JZERO = 7'd43;
    localparam logic [OPC_W-1:0] OP_HALT  = 7'd99;
    // never produced by the split, marks words that decode to no opcode
    localparam logic [OPC_W-1:0] OP_BAD   = 7'd127;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_START,
        CMD_STEP
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK,
        ST_HALTED,
        ST_IDLE,
        ST_UNKNOWN,
        ST_ZERODIV,
        ST_OVERRUN
    } t_status;

    typedef logic signed [IO_W-1:0] t_io;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        t_io               data_in;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] program_counter;
        t_io               accumulator_value;
        t_io               data_out;
        logic              data_out_valid;
        logic              input_used;
    } t_out;

endpackage

/* rtl/decimal_accumulator_cpu.sv */
// decimal-coded accumulator cpu with a 100-word memory and a shared add/subtract unit
// multiply and power run on the bit-serial multiplier, divide and modulo bit-serially
// one beat at a time: input stall drops as the result enters the output register
// sync active-low reset clears pc, accumulator, running, out valid, memory valid bits
module decimal_accumulator_cpu #(
    parameter int WORD_BITS = dacc_pkg::WORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dacc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dacc_pkg::t_out o_out_data
);

    localparam int AW    = dacc_pkg::ADDR_W;
    localparam int CNT_W = $clog2(WORD_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [WORD_BITS-1:0]        t_uword;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDWAIT,
        S_FETCH,
        S_OPRD,
        S_EXEC,
        S_MUL,
        S_PW_CHK,
        S_PW_SQ,
        S_DIV,
        S_DIV_FIN,
        S_DONE
    } t_state;

    // control
    t_state                     r_state;
    logic                       r_running;
    logic [AW-1:0]              r_pc;
    t_word                      r_acc;

    // memory, one write and one registered read per cycle, valid bit per word
    t_word                      r_mem [dacc_pkg::MEM_WORDS];
    logic [dacc_pkg::MEM_WORDS-1:0] r_vld;
    t_word                      r_rdata;
    logic                       r_rvld;

    // beat in flight
    t_word                      r_din;
    logic                       r_rd_ok;
    logic [dacc_pkg::OPC_W-1:0] r_op;
    logic [AW-1:0]              r_a;

    // multiplier, power and divider working registers
    t_uword                     r_prod;
    t_uword                     r_mcand;
    t_uword                     r_mplier;
    logic                       r_pow;
    logic                       r_pow_res;
    t_uword                     r_base;
    t_uword                     r_exp;
    t_uword                     r_pres;
    t_uword                     r_rem;
    t_uword                     r_quo;
    t_uword                     r_dvsr;
    logic                       r_div_q;
    logic                       r_neg;
    logic [CNT_W-1:0]           r_cnt;

    // result fields and output register
    dacc_pkg::t_status          r_status;
    t_word                      r_dout;
    logic                       r_dvalid;
    logic                       r_used;
    dacc_pkg::t_out             r_out;
    logic                       r_out_valid;

    // combinational
    t_word                      din_w;
    t_word                      word_q;
    logic                       addr_ok;
    logic                       out_free;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    t_word                      mem_wdata;
    logic [AW-1:0]              mem_raddr;
    t_uword                     alu_a;
    t_uword                     alu_b;
    logic                       alu_sub;
    logic [WORD_BITS:0]         alu_y;
    t_uword                     acc_mag;
    t_uword                     m_mag;
    t_uword                     rem_sh;
    t_uword                     div_r;
    logic [dacc_pkg::SPLIT_W-1:0] dec_v;
    logic [dacc_pkg::SPLIT_W+dacc_pkg::RECIP_W-1:0] dec_p;
    logic [dacc_pkg::OPC_W-1:0] dec_q;
    logic [dacc_pkg::SPLIT_W-1:0] dec_rem;
    logic [dacc_pkg::OPC_W-1:0] dec_op;
    logic [AW-1:0]              dec_a;
    logic [AW-1:0]              exec_pc;

    assign din_w    = t_word'(i_in_data.data_in);
    assign word_q   = r_rvld ? r_rdata : '0;
    assign addr_ok  = int'(i_in_data.address) < dacc_pkg::MEM_WORDS;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // magnitudes for the signed divide; most negative stays as 2^(W-1) unsigned
    assign acc_mag = r_acc[WORD_BITS-1] ? t_uword'(-r_acc) : t_uword'(r_acc);
    assign m_mag   = word_q[WORD_BITS-1] ? t_uword'(-word_q) : t_uword'(word_q);
    assign rem_sh  = {r_rem[WORD_BITS-2:0], r_quo[WORD_BITS-1]};
    assign div_r   = r_div_q ? r_quo : r_rem;

    // instruction split: reciprocal multiply is exact for words below 100*100
    assign dec_v   = word_q[dacc_pkg::SPLIT_W-1:0];
    assign dec_p   = ($bits(dec_p))'(dec_v)
                   * ($bits(dec_p))'(dacc_pkg::DIV_RECIP);
    assign dec_q   = dec_p[dacc_pkg::DIV_SHIFT +: dacc_pkg::OPC_W];
    assign dec_rem = dec_v - ($bits(dec_rem))'(dec_q)
                   * ($bits(dec_rem))'(dacc_pkg::OP_SPLIT);

    always_comb begin
        dec_op = dacc_pkg::OP_BAD;
        dec_a  = '0;
        if (!word_q[WORD_BITS-1]) begin
            if (word_q < t_word'(dacc_pkg::INSN_LIMIT)) begin
                dec_op = dec_q;
                dec_a  = dec_rem[AW-1:0];
            end
        end else if (word_q > t_word'(-dacc_pkg::OP_SPLIT)) begin
            // small negative words act as no-op
            dec_op = dacc_pkg::OP_NOP;
        end
    end

    // next pc of an executed instruction, taken jumps go to the operand address
    always_comb begin
        exec_pc = r_pc + 1'b1;
        case (r_op)
            dacc_pkg::OP_JMP: begin
                exec_pc = r_a;
            end
            dacc_pkg::OP_JNEG: begin
                if (r_acc[WORD_BITS-1]) begin
                    exec_pc = r_a;
                end
            end
            dacc_pkg::OP_JPOS: begin
                if (!r_acc[WORD_BITS-1] && r_acc != '0) begin
                    exec_pc = r_a;
                end
            end
            dacc_pkg::OP_JZERO: begin
                if (r_acc == '0) begin
                    exec_pc = r_a;
                end
            end
            default: begin
            end
        endcase
    end

    // shared add/subtract unit
    assign alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_op)
                    dacc_pkg::OP_ADD: begin
                        alu_a = t_uword'(r_acc);
                        alu_b = t_uword'(word_q);
                    end
                    dacc_pkg::OP_SUB: begin
                        alu_a   = t_uword'(r_acc);
                        alu_b   = t_uword'(word_q);
                        alu_sub = 1'b1;
                    end
                    dacc_pkg::OP_INC: begin
                        alu_a = t_uword'(word_q);
                        alu_b = t_uword'(1);
                    end
                    dacc_pkg::OP_DEC: begin
                        alu_a   = t_uword'(word_q);
                        alu_b   = t_uword'(1);
                        alu_sub = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                alu_a = r_prod;
                alu_b = r_mcand;
            end
            S_DIV: begin
                alu_a   = rem_sh;
                alu_b   = r_dvsr;
                alu_sub = 1'b1;
            end
            S_DIV_FIN: begin
                alu_b   = div_r;
                alu_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_a;
        mem_wdata = r_din;
        mem_raddr = r_a;
        if (r_state == S_IDLE) begin
            if (i_in_data.cmd == dacc_pkg::CMD_STEP) begin
                mem_raddr = (int'(r_pc) < dacc_pkg::MEM_WORDS) ? r_pc : '0;
            end else begin
                mem_raddr = addr_ok ? i_in_data.address : '0;
            end
            if (i_in_valid && i_in_data.cmd == dacc_pkg::CMD_WRITE && addr_ok) begin
                mem_we    = 1'b1;
                mem_waddr = i_in_data.address;
                mem_wdata = din_w;
            end
        end else if (r_state == S_EXEC) begin
            case (r_op)
                dacc_pkg::OP_INPUT: begin
                    mem_we = 1'b1;
                end
                dacc_pkg::OP_STORE: begin
                    mem_we    = 1'b1;
                    mem_wdata = r_acc;
                end
                dacc_pkg::OP_INC, dacc_pkg::OP_DEC: begin
                    mem_we    = 1'b1;
                    mem_wdata = t_word'(alu_y[WORD_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
        r_rvld  <= r_vld[mem_raddr];
    end

    // valid bits stand in for the all-zero memory reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_waddr] <= 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_pc        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a drained output register empties unless a new result loads it
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dout   <= '0;
                        r_dvalid <= 1'b0;
                        r_used   <= 1'b0;
                        r_din    <= din_w;
                        r_rd_ok  <= addr_ok;
                        case (i_in_data.cmd)
                            dacc_pkg::CMD_WRITE: begin
                                r_status <= dacc_pkg::ST_OK;
                                r_state  <= S_DONE;
                            end
                            dacc_pkg::CMD_READ: begin
                                r_status <= dacc_pkg::ST_OK;
                                r_state  <= S_RDWAIT;
                            end
                            dacc_pkg::CMD_START: begin
                                r_pc      <= '0;
                                r_acc     <= '0;
                                r_running <= 1'b1;
                                r_status  <= dacc_pkg::ST_OK;
                                r_state   <= S_DONE;
                            end
                            dacc_pkg::CMD_STEP: begin
                                if (!r_running) begin
                                    r_status <= dacc_pkg::ST_IDLE;
                                    r_state  <= S_DONE;
                                end else if (int'(r_pc) >= dacc_pkg::MEM_WORDS) begin
                                    // ran off the end of memory
                                    r_running <= 1'b0;
                                    r_status  <= dacc_pkg::ST_OVERRUN;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_status <= dacc_pkg::ST_OK;
                                    r_state  <= S_FETCH;
                                end
                            end
                            default: begin
                                r_status <= dacc_pkg::ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    if (r_rd_ok) begin
                        r_dout   <= word_q;
                        r_dvalid <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_FETCH: begin
                    r_op    <= dec_op;
                    r_a     <= dec_a;
                    r_state <= S_OPRD;
                end
                S_OPRD: begin
                    // operand word read at r_a
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pc <= exec_pc;
                    case (r_op)
                        dacc_pkg::OP_NOP, dacc_pkg::OP_NOP2, dacc_pkg::OP_STORE,
                        dacc_pkg::OP_INC, dacc_pkg::OP_DEC, dacc_pkg::OP_JMP,
                        dacc_pkg::OP_JNEG, dacc_pkg::OP_JPOS, dacc_pkg::OP_JZERO: begin
                            r_state <= S_DONE;
                        end
                        dacc_pkg::OP_INPUT: begin
                            r_used  <= 1'b1;
                            r_state <= S_DONE;
                        end
                        dacc_pkg::OP_PRINT: begin
                            r_dout   <= word_q;
                            r_dvalid <= 1'b1;
                            r_state  <= S_DONE;
                        end
                        dacc_pkg::OP_LOAD: begin
                            r_acc   <= word_q;
                            r_state <= S_DONE;
                        end
                        dacc_pkg::OP_ADD, dacc_pkg::OP_SUB: begin
                            r_acc   <= t_word'(alu_y[WORD_BITS-1:0]);
                            r_state <= S_DONE;
                        end
                        dacc_pkg::OP_MUL: begin
                            r_prod   <= '0;
                            r_mcand  <= t_uword'(r_acc);
                            r_mplier <= t_uword'(word_q);
                            r_pow    <= 1'b0;
                            r_state  <= S_MUL;
                        end
                        dacc_pkg::OP_DIV, dacc_pkg::OP_MOD: begin
                            if (word_q == '0) begin
                                r_status <= dacc_pkg::ST_ZERODIV;
                                r_state  <= S_DONE;
                            end else begin
                                r_rem   <= '0;
                                r_quo   <= acc_mag;
                                r_dvsr  <= m_mag;
                                r_div_q <= (r_op == dacc_pkg::OP_DIV);
                                // remainder takes the dividend's sign
                                r_neg   <= (r_op == dacc_pkg::OP_DIV)
                                         ? (r_acc[WORD_BITS-1] ^ word_q[WORD_BITS-1])
                                         : r_acc[WORD_BITS-1];
                                r_cnt   <= CNT_W'(WORD_BITS);
                                r_state <= S_DIV;
                            end
                        end
                        dacc_pkg::OP_POW: begin
                            if (word_q[WORD_BITS-1] || word_q == '0) begin
                                r_acc   <= t_word'(1);
                                r_state <= S_DONE;
                            end else begin
                                r_base  <= t_uword'(r_acc);
                                r_exp   <= t_uword'(word_q);
                                r_pres  <= t_uword'(1);
                                r_state <= S_PW_CHK;
                            end
                        end
                        dacc_pkg::OP_HALT: begin
                            r_running <= 1'b0;
                            r_status  <= dacc_pkg::ST_HALTED;
                            r_state   <= S_DONE;
                        end
                        default: begin
                            r_status <= dacc_pkg::ST_UNKNOWN;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_MUL: begin
                    // shift-add, one multiplier bit per cycle, stops when no bits remain
                    if (r_mplier == '0) begin
                        if (!r_pow) begin
                            r_acc   <= t_word'(r_prod);
                            r_state <= S_DONE;
                        end else if (r_pow_res) begin
                            r_pres  <= r_prod;
                            r_state <= S_PW_SQ;
                        end else begin
                            r_base  <= r_prod;
                            r_state <= S_PW_CHK;
                        end
                    end else begin
                        if (r_mplier[0]) begin
                            r_prod <= alu_y[WORD_BITS-1:0];
                        end
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_PW_CHK: begin
                    if (r_exp[0]) begin
                        r_prod    <= '0;
                        r_mcand   <= r_pres;
                        r_mplier  <= r_base;
                        r_pow     <= 1'b1;
                        r_pow_res <= 1'b1;
                        r_state   <= S_MUL;
                    end else begin
                        r_state <= S_PW_SQ;
                    end
                end
                S_PW_SQ: begin
                    if ((r_exp >> 1) == '0) begin
                        r_acc   <= t_word'(r_pres);
                        r_state <= S_DONE;
                    end else begin
                        r_exp     <= r_exp >> 1;
                        r_prod    <= '0;
                        r_mcand   <= r_base;
                        r_mplier  <= r_base;
                        r_pow     <= 1'b1;
                        r_pow_res <= 1'b0;
                        r_state   <= S_MUL;
                    end
                end
                S_DIV: begin
                    // restoring divide on magnitudes, one quotient bit per cycle
                    if (r_cnt == '0) begin
                        r_state <= S_DIV_FIN;
                    end else begin
                        if (!alu_y[WORD_BITS]) begin
                            r_rem <= alu_y[WORD_BITS-1:0];
                            r_quo <= {r_quo[WORD_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[WORD_BITS-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV_FIN: begin
                    r_acc   <= r_neg ? t_word'(alu_y[WORD_BITS-1:0]) : t_word'(div_r);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // result beat waits here until the output register is free
                    if (out_free) begin
                        r_out.status            <= r_status;
                        r_out.program_counter   <= r_pc;
                        r_out.accumulator_value <= dacc_pkg::t_io'(r_acc);
                        r_out.data_out          <= dacc_pkg::t_io'(r_dout);
                        r_out.data_out_valid    <= r_dvalid;
                        r_out.input_used        <= r_used;
                        r_out_valid             <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // one beat at a time: input closes right after an accept
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a beat is in flight");

    // finished result is held until the output register drains
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_out_valid && i_out_stall
        |=> r_state == S_DONE && $stable(r_out))
        else $error("pending result overwrote the output register");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> int'(mem_waddr) < dacc_pkg::MEM_WORDS)
        else $error("memory write outside the word range");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dvsr != '0)
        else $error("divide loop started with zero divisor");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> int'(r_pc) <= dacc_pkg::MEM_WORDS)
        else $error("pc beyond the end of memory");

endmodule

/* test/tb_decimal_accumulator_cpu.sv */
// self-checking testbench for the decimal accumulator cpu
module tb_decimal_accumulator_cpu;
    import dacc_pkg::*;

    // about how many command beats the random part sends
    localparam int ITEM_GOAL = 1250;
    // slowest beat: power on the bit-serial multiplier, plus sender gap and receiver stall
    localparam int POW_CYCLES = 2 * IO_W * (IO_W + 2);
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_RESULT = 400;
    localparam int CYCLE_LIMIT = 1400 * (POW_CYCLES + 200) * 4 + HOLD_CYCLES;
    localparam int DRAIN_CYCLES = POW_CYCLES + 100;
    localparam int MAX_REPORTS = 10;

    localparam t_io WORD_MIN = {1'b1, {(IO_W - 1){1'b0}}};
    localparam t_io WORD_MAX = {1'b0, {(IO_W - 1){1'b1}}};

    // opcodes the program generator draws from; power is drawn separately and rarely
    localparam logic [OPC_W-1:0] PLAIN_OPS [18] = '{
        OP_NOP, OP_INPUT, OP_PRINT, OP_NOP2, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV,
        OP_MUL, OP_MOD, OP_DEC, OP_INC, OP_JMP, OP_JNEG, OP_JPOS, OP_JZERO, OP_HALT
    };

    // marks a word that decodes to no opcode at all
    localparam int OP_NONE = -1;

    // shadow machine: memory, accumulator, pc and run flag, plus results still due
    class cpu_scoreboard;
        t_io  words [MEM_WORDS];
        t_io  acc;
        int   pc;
        bit   running;
        t_out results_due [$];
        int   mismatches;
        int   results_seen;

        function new();
            foreach (words[i]) words[i] = '0;
            acc = '0;
            pc = 0;
            running = 1'b0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // run one accepted command on the shadow machine and queue its result
        function void take_command(t_in beat);
            t_out            res;
            t_io             w;
            t_io             m;
            t_io             base;
            t_io             prod;
            logic [IO_W-1:0] e;
            int              op;
            int              a;
            int              nxt;
            longint          mag_a;
            longint          mag_b;
            longint          quo;
            bit              neg;

            res = '0;
            res.status = ST_OK;
            case (beat.cmd)
                CMD_WRITE: begin
                    // out-of-range address: silently dropped
                    if (beat.address < MEM_WORDS) words[beat.address] = beat.data_in;
                end
                CMD_READ: begin
                    if (beat.address < MEM_WORDS) begin
                        res.data_out = words[beat.address];
                        res.data_out_valid = 1'b1;
                    end
                end
                CMD_START: begin
                    pc = 0;
                    acc = '0;
                    running = 1'b1;
                end
                default: begin
                    if (!running) begin
                        res.status = ST_IDLE;
                    end else if (pc >= MEM_WORDS) begin
                        running = 1'b0;
                        res.status = ST_OVERRUN;
                    end else begin
                        w = words[pc];
                        a = 0;
                        nxt = pc + 1;
                        // negative words: -99..-1 act as no-op, anything lower is junk
                        if (w < 0) begin
                            op = (w > -OP_SPLIT) ? int'(OP_NOP) : OP_NONE;
                        end else begin
                            op = w / OP_SPLIT;
                            a = w % OP_SPLIT;
                        end
                        m = words[a];
                        case (op)
                            OP_NOP, OP_NOP2: ;
                            OP_INPUT: begin
                                words[a] = beat.data_in;
                                res.input_used = 1'b1;
                            end
                            OP_PRINT: begin
                                res.data_out = m;
                                res.data_out_valid = 1'b1;
                            end
                            OP_LOAD:  acc = m;
                            OP_STORE: words[a] = acc;
                            OP_ADD:   acc = acc + m;
                            OP_SUB:   acc = acc - m;
                            OP_MUL:   acc = acc * m;
                            OP_DIV, OP_MOD: begin
                                if (m == 0) begin
                                    res.status = ST_ZERODIV;
                                end else begin
                                    // sign-magnitude, truncating toward zero
                                    mag_a = (acc < 0) ? -longint'(acc) : longint'(acc);
                                    mag_b = (m < 0) ? -longint'(m) : longint'(m);
                                    if (op == OP_DIV) begin
                                        quo = mag_a / mag_b;
                                        neg = (acc < 0) != (m < 0);
                                    end else begin
                                        quo = mag_a % mag_b;
                                        neg = acc < 0;
                                    end
                                    if (neg) quo = -quo;
                                    acc = quo[IO_W-1:0];
                                end
                            end
                            OP_POW: begin
                                if (m <= 0) begin
                                    acc = 1;
                                end else begin
                                    prod = 1;
                                    base = acc;
                                    e = m;
                                    while (e != 0) begin
                                        if (e[0]) prod = prod * base;
                                        base = base * base;
                                        e = e >> 1;
                                    end
                                    acc = prod;
                                end
                            end
                            OP_DEC:   words[a] = m - 1;
                            OP_INC:   words[a] = m + 1;
                            OP_JMP:   nxt = a;
                            OP_JNEG:  if (acc < 0) nxt = a;
                            OP_JPOS:  if (acc > 0) nxt = a;
                            OP_JZERO: if (acc == 0) nxt = a;
                            OP_HALT: begin
                                running = 1'b0;
                                res.status = ST_HALTED;
                            end
                            default:  res.status = ST_UNKNOWN;
                        endcase
                        pc = nxt;
                    end
                end
            endcase
            res.program_counter = ADDR_W'(pc);
            res.accumulator_value = acc;
            results_due.push_back(res);
        endfunction

        function void flag(string what, t_out want, t_out got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%s: expected st=%0d pc=%0d acc=%0d dout=%0d dv=%0b in=%0b,",
                         what, want.status, want.program_counter, want.accumulator_value,
                         want.data_out, want.data_out_valid, want.input_used);
                $display("    got st=%0d pc=%0d acc=%0d dout=%0d dv=%0b in=%0b",
                         got.status, got.program_counter, got.accumulator_value,
                         got.data_out, got.data_out_valid, got.input_used);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;

            results_seen++;
            if (results_due.size() == 0) begin
                flag("result with nothing pending", '0, got);
                return;
            end
            want = results_due.pop_front();
            if (got.status !== want.status
                || got.program_counter !== want.program_counter
                || got.accumulator_value !== want.accumulator_value
                || got.data_out !== want.data_out
                || got.data_out_valid !== want.data_out_valid
                || got.input_used !== want.input_used)
                flag($sformatf("result %0d differs", results_seen), want, got);
        endfunction
    endclass

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // idle and stall odds in percent, changed per phase by the stimulus
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_done = 0;

    cpu_scoreboard sb = new();

    decimal_accumulator_cpu dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // offer one beat, with a random gap first, and hold it until it is taken
    task automatic send_beat(t_in beat);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        // taken at this edge; predict right away so the queue leads the output
        sb.take_command(beat);
    endtask

    task automatic send_cmd(t_cmd cmd, int addr, t_io word);
        t_in beat;

        beat.cmd     = cmd;
        beat.address = ADDR_W'(addr);
        beat.data_in = word;
        send_beat(beat);
        items_done++;
    endtask

    function automatic t_io encode(int op, int a);
        return op * OP_SPLIT + a;
    endfunction

    // operand words lean on the corners: zero, extremes, small values
    function automatic t_io pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return WORD_MIN;
            2:       return WORD_MAX;
            3:       return -1;
            4, 5:    return int'($urandom_range(40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    // stray reads and writes, some of them outside the memory
    task automatic send_noise();
        t_in beat;

        beat.cmd     = $urandom_range(1) ? CMD_READ : CMD_WRITE;
        beat.address = ADDR_W'($urandom_range(127));
        beat.data_in = pick_word();
        send_beat(beat);
    endtask

    // one instruction word; jumps stay near the program, data ops hit the upper memory
    function automatic t_io make_insn(int len);
        int pick;
        int op;

        pick = $urandom_range(99);
        if (pick < 4) return $urandom;
        if (pick < 8) return -int'($urandom_range(1, 150));
        op = (pick < 11) ? int'(OP_POW) : int'(PLAIN_OPS[$urandom_range(17)]);
        if (op >= OP_JMP && op <= OP_JZERO) return encode(op, $urandom_range(len));
        return encode(op, $urandom_range(60, 99));
    endfunction

    // load operands, load a short program at address 0, start it and step it
    task automatic run_program();
        int len;
        int steps;
        bit to_the_end;

        len = $urandom_range(3, 14);
        to_the_end = $urandom_range(9) == 0;
        repeat ($urandom_range(2, 6)) send_cmd(CMD_WRITE, $urandom_range(60, 99), pick_word());
        for (int k = 0; k < len; k++) begin
            // now and then jump into the top words so the pc can run off the memory
            if (to_the_end && k == len - 1)
                send_cmd(CMD_WRITE, k, encode(OP_JMP, $urandom_range(95, 99)));
            else
                send_cmd(CMD_WRITE, k, make_insn(len));
        end
        send_cmd(CMD_START, $urandom_range(127), $urandom);
        steps = to_the_end ? len + 10 : $urandom_range(len, 3 * len);
        repeat (steps) begin
            if ($urandom_range(99) < 6)
                send_noise();
            else
                send_cmd(CMD_STEP, $urandom_range(127), $urandom);
        end
        repeat ($urandom_range(3)) send_cmd(CMD_READ, $urandom_range(99), $urandom);
    endtask

    // result side: random stalls, plus one long hold-off so the input backs up
    initial begin
        bit held;

        held = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
            if (!held && sb.results_seen == HOLD_AT_RESULT) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    initial begin
        int cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int episode;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle step, dropped out-of-range accesses, then a short program that
        // walks through most-negative divided by -1, modulo by zero, a small negative
        // no-op, a junk word, power with a negative exponent and a run off the memory
        send_cmd(CMD_STEP, 0, '0);
        send_cmd(CMD_WRITE, 127, WORD_MAX);
        send_cmd(CMD_READ, 100, '0);
        send_cmd(CMD_READ, 0, WORD_MIN);
        send_cmd(CMD_WRITE, 99, WORD_MIN);
        send_cmd(CMD_WRITE, 98, -1);
        send_cmd(CMD_WRITE, 0, encode(OP_LOAD, 99));
        send_cmd(CMD_WRITE, 1, encode(OP_DIV, 98));
        send_cmd(CMD_WRITE, 2, encode(OP_MOD, 97));
        send_cmd(CMD_WRITE, 3, -50);
        send_cmd(CMD_WRITE, 4, -100);
        send_cmd(CMD_WRITE, 5, encode(OP_POW, 98));
        send_cmd(CMD_WRITE, 6, encode(OP_JMP, 99));
        send_cmd(CMD_START, 0, '0);
        // the last of these runs the junk word at 99 and leaves pc at 100
        repeat (8) send_cmd(CMD_STEP, 0, $urandom);
        send_cmd(CMD_STEP, 0, '0);
        send_cmd(CMD_READ, 99, '0);
        send_cmd(CMD_STEP, 0, '0);

        // random programs, rotating through the idling phases a few episodes at a time
        episode = 0;
        items_done = 0;
        while (items_done < ITEM_GOAL) begin
            case ((episode / 4) % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default: begin
                    idle_pct  = 29;
                    stall_pct = 29;
                end
            endcase
            run_program();
            episode++;
        end
        in_valid <= 1'b0;

        while (sb.results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.results_due.size() != 0)
            $display("%0d results never arrived", sb.results_due.size());
        if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
